@@ design/rgtc_pkg.sv @@
// Package for the rain gauge tip counter: widths, timing constants,
// configuration register map and the saturating count helper.
// No dependencies; used by the channel interfaces and the top level.
package rgtc_pkg;

  // Tick timing (one tick is 25 ms)
  localparam int unsigned SETTLE_TICKS     = 12;
  localparam int unsigned TICKS_PER_MINUTE = 2400;

  // Field widths
  localparam int unsigned CNT_W    = 24;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned MIN_W    = 11;
  localparam int unsigned TMR_W    = 22;

  // Settle counter must hold SETTLE_TICKS + 1 before it wraps to idle
  localparam int unsigned SETTLE_W = $clog2(SETTLE_TICKS + 2);

  // Interval target before clamping: largest minutes value times ticks per minute
  localparam int unsigned PROD_W = $clog2(((1 << MIN_W) - 1) * TICKS_PER_MINUTE + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [TMR_W-1:0] TMR_MAX = {TMR_W{1'b1}};

  // APB register map
  localparam int unsigned REG_COUNT = 3;
  localparam int unsigned IDX_W     = $clog2(REG_COUNT);
  localparam int unsigned ADDR_W    = IDX_W + 2;
  localparam int unsigned DATA_W    = 32;

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE   = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_PRESET   = 2'd2
  } reg_idx_t;

  // Saturating increment of a tip count
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

@@ design/rgtc_channels.sv @@
// Valid/ready channel interfaces for the rain gauge tip counter:
// one for tick requests, one for per-tick results.
// Depends on rgtc_pkg for field widths.
interface rgtc_in_if;
  import rgtc_pkg::*;

  logic                valid;
  logic                ready;
  logic                pin_level;
  logic [HOUR_W-1:0]   clock_hour;
  logic [MINUTE_W-1:0] clock_minute;

  modport source (output valid, output pin_level, output clock_hour,
                  output clock_minute, input ready);
  modport sink   (input valid, input pin_level, input clock_hour,
                  input clock_minute, output ready);
endinterface

interface rgtc_out_if;
  import rgtc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] interval_count;
  logic [CNT_W-1:0] total_count;
  logic             report_valid;
  logic [CNT_W-1:0] report_count;

  modport source (output valid, output interval_count, output total_count,
                  output report_valid, output report_count, input ready);
  modport sink   (input valid, input interval_count, input total_count,
                  input report_valid, input report_count, output ready);
endinterface

@@ design/rain_gauge_tip_counter.sv @@
// Rain gauge tip counter top level: input register, tick logic, result register
// and the APB configuration registers.
// Depends on rgtc_pkg and the channel interfaces in rgtc_channels.sv.
//
// Usage:
//   in_ch carries one request per 25 ms tick: switch level plus clock hour and
//   minute. out_ch returns exactly one result per tick: interval and total tip
//   counts after the tick, and a report flag with the captured interval count.
//   An accepted request passes through the input register, then the result
//   register. Throughput is one tick per cycle unless the receiver stalls; the
//   single tick update of the counters between the two registers sets that rate.
//   If the receiver stalls, the result register holds and the input register
//   fills; in_ch.ready drops only when both are occupied, and rises again in the
//   cycle the result is taken.
//   Configuration goes over APB: enable at 0x0, interval_minutes at 0x4,
//   total_preset at 0x8. Setting enable from 0 to 1 loads the total count from
//   total_preset and clears the interval count and the debounce state. While
//   enable is 0 ticks pass through unchanged with no report.
//   Synchronous reset clears the configuration registers, tick counters and
//   both valid flags; the block accepts requests in the first cycle after reset.
module rain_gauge_tip_counter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rgtc_pkg::ADDR_W-1:0] paddr,
  input  logic [rgtc_pkg::DATA_W-1:0] pwdata,
  output logic [rgtc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  rgtc_in_if.sink                    in_ch,
  rgtc_out_if.source                 out_ch
);
  import rgtc_pkg::*;

  // Configuration registers
  logic             enable;
  logic [MIN_W-1:0] interval_minutes;
  logic [CNT_W-1:0] total_preset;
  logic [TMR_W-1:0] target_ticks;

  // Tick state
  logic                last_level;
  logic [SETTLE_W-1:0] settle_ticks;
  logic [TMR_W-1:0]    interval_ticks;
  logic [CNT_W-1:0]    tips_interval;
  logic [CNT_W-1:0]    tips_total;

  // Input stage
  logic                s1_valid;
  logic                pin_q;
  logic [HOUR_W-1:0]   hour_q;
  logic [MINUTE_W-1:0] minute_q;

  // Handshake
  logic in_fire;
  logic s1_fire;
  logic out_free;

  // Next state
  logic                last_level_next;
  logic [SETTLE_W-1:0] settle_start;
  logic [SETTLE_W-1:0] settle_ticks_next;
  logic [TMR_W-1:0]    ticks_inc;
  logic [TMR_W-1:0]    interval_ticks_next;
  logic [CNT_W-1:0]    tips_interval_next;
  logic [CNT_W-1:0]    tips_total_next;
  logic                report;
  logic [CNT_W-1:0]    captured;

  // Config decode
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  logic [PROD_W-1:0] target_raw;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Interval target in ticks, clamped to the timer range
  assign target_raw = PROD_W'(pwdata[MIN_W-1:0]) * PROD_W'(TICKS_PER_MINUTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable           <= 1'b0;
      interval_minutes <= '0;
      total_preset     <= '0;
      target_ticks     <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE: begin
          enable <= pwdata[0];
        end
        REG_INTERVAL: begin
          interval_minutes <= pwdata[MIN_W-1:0];
          target_ticks     <= (target_raw > PROD_W'(TMR_MAX)) ? TMR_MAX
                                                             : target_raw[TMR_W-1:0];
        end
        REG_PRESET: begin
          total_preset <= pwdata[CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_ENABLE:   prdata = DATA_W'(enable);
      REG_INTERVAL: prdata = DATA_W'(interval_minutes);
      REG_PRESET:   prdata = DATA_W'(total_preset);
      default:      prdata = '0;
    endcase
  end

  // Pipeline handshake: result register frees when taken, input stage
  // advances whenever the result register can load
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign s1_fire     = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pin_q    <= in_ch.pin_level;
      hour_q   <= in_ch.clock_hour;
      minute_q <= in_ch.clock_minute;
    end
  end

  // Tick update: edge detect, interval timer, settle and tip, daily clear,
  // then report capture
  always_comb begin
    last_level_next     = last_level;
    settle_ticks_next   = settle_ticks;
    interval_ticks_next = interval_ticks;
    tips_interval_next  = tips_interval;
    tips_total_next     = tips_total;
    report              = 1'b0;
    captured            = '0;
    settle_start        = (pin_q != last_level) ? SETTLE_W'(1) : settle_ticks;
    ticks_inc           = (interval_ticks == TMR_MAX) ? interval_ticks
                                                      : interval_ticks + TMR_W'(1);
    if (enable) begin
      last_level_next     = pin_q;
      interval_ticks_next = ticks_inc;
      if ((target_ticks != '0) && (ticks_inc >= target_ticks)) begin
        interval_ticks_next = '0;
        report              = 1'b1;
      end
      // settle counter runs from the edge tick; a tip lands once it passes the limit
      if (settle_start != '0) begin
        settle_ticks_next = settle_start + SETTLE_W'(1);
        if (settle_ticks_next > SETTLE_W'(SETTLE_TICKS)) begin
          settle_ticks_next  = '0;
          tips_interval_next = sat_inc(tips_interval);
          tips_total_next    = sat_inc(tips_total);
        end
      end
      // daily clear at 00:00 and 00:01
      if ((hour_q == '0) && ((minute_q == '0) || (minute_q == MINUTE_W'(1)))) begin
        tips_interval_next = '0;
        tips_total_next    = '0;
      end
      if (report) begin
        captured           = tips_interval_next;
        tips_interval_next = '0;
      end
    end
  end

  // Tick state; an enable 0 -> 1 write reloads the counts
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b0;
      settle_ticks   <= '0;
      interval_ticks <= '0;
      tips_interval  <= '0;
      tips_total     <= '0;
    end else begin
      if (s1_fire) begin
        last_level     <= last_level_next;
        settle_ticks   <= settle_ticks_next;
        interval_ticks <= interval_ticks_next;
        tips_interval  <= tips_interval_next;
        tips_total     <= tips_total_next;
      end
      if (cfg_wr && (cfg_idx == REG_ENABLE) && pwdata[0] && !enable) begin
        tips_total    <= total_preset;
        tips_interval <= '0;
        last_level    <= 1'b0;
        settle_ticks  <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (s1_fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_ch.interval_count <= tips_interval_next;
      out_ch.total_count    <= tips_total_next;
      out_ch.report_valid   <= report;
      out_ch.report_count   <= captured;
    end
  end

`ifndef SYNTHESIS
  // settle counter never holds a value past its limit
  a_settle_range: assert property (@(posedge clk) disable iff (rst)
    settle_ticks <= SETTLE_W'(SETTLE_TICKS))
    else $error("settle counter out of range");

  // a disabled tick leaves the total count alone
  a_disabled_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !enable && !cfg_wr) |=> $stable(tips_total))
    else $error("total count changed while disabled");

  // a report always leaves the interval count cleared
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && report) |=> (tips_interval == '0))
    else $error("interval count not cleared after report");

  // requests are refused only when the input stage holds a stalled tick
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (s1_valid && out_ch.valid && !out_ch.ready))
    else $error("input refused without a stall");
`endif

endmodule
